>>> rtl/tle_pkg.sv
// Shared types and constants for the terminal line editor.
package tle_pkg;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int CODE_W   = 32;
    localparam int MAXB_W   = 7;
    localparam int CHAR_W   = 8;

    // Request selector carried on the input side.
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ECHO    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DATA    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RAW     = 3'd4;

    // Key codes, compared over the full code width.
    localparam logic [CODE_W-1:0] KEY_BS    = 32'h0000_0008;
    localparam logic [CODE_W-1:0] KEY_LF    = 32'h0000_000A;
    localparam logic [CODE_W-1:0] KEY_CR    = 32'h0000_000D;
    localparam logic [CODE_W-1:0] KEY_SPACE = 32'h0000_0020;
    localparam logic [CODE_W-1:0] KEY_DEL   = 32'h0000_007F;

    typedef struct packed {
        logic is_newline;
        logic is_erase;
        logic is_print;
    } key_class_t;

endpackage

>>> rtl/tty_line_editor_unit.sv
// Top level of the canonical terminal line editor.
//
//  Channel  Direction  Signals                         Contents
//  s_*      in         tvalid tready tdata tuser       key event or read request
//  m_*      out        tvalid tready tdata tlast       echo, line data, status or raw event
//  cfg_*    in         valid ready data                raw_mode register
//
// A request is captured in one cycle and decoded in the next, which also loads the
// first result; an erase then echoes a space and a backspace from its own state. A read
// burst primes the line memory in the decode cycle and then streams one stored byte per
// cycle while the output is not stalled. Reset needs no clearing pass. A stalled output
// holds the sequencer in place; the next request is taken as soon as the last result
// of the previous one sits in the output register.
module tty_line_editor_unit
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = 256,
    parameter int READ_BURST    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] key_code, [38:32] max_bytes, [39] zero
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] kind, [34:3] value, [39:35] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int ADDR_W = $clog2(LINE_CAPACITY);
    localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
    localparam int CMP_W  = (LEN_W > MAXB_W) ? LEN_W : MAXB_W;
    localparam logic [LEN_W-1:0]  CAP_LEN  = LEN_W'(LINE_CAPACITY);
    localparam logic [LEN_W-1:0]  CAP_LEN1 = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [MAXB_W-1:0] BURST    = MAXB_W'(READ_BURST);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ERASE,
        ST_READ
    } state_t;

    state_t              state_reg, state_next;
    logic                raw_reg;
    logic                func_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [MAXB_W-1:0]   maxb_reg;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    cursor_reg, cursor_next;
    logic                ready_reg, ready_next;
    logic [MAXB_W-1:0]   remain_reg, remain_next;
    logic                erase_step_reg, erase_step_next;
    logic                m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]   m_kind_reg, m_kind_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;
    logic                m_last_reg, m_last_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CHAR_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [CHAR_W-1:0]   mem_rdata;

    key_class_t          key_class;
    logic                slot_free;
    logic [MAXB_W-1:0]   limit;
    logic [CMP_W-1:0]    diff_w;
    logic [CMP_W-1:0]    limit_w;
    logic [CMP_W-1:0]    avail_w;
    logic [MAXB_W-1:0]   avail;
    logic [LEN_W-1:0]    cursor_inc;
    logic                load;
    logic [KIND_W-1:0]   ld_kind;
    logic [VALUE_W-1:0]  ld_value;
    logic                ld_last;

    tle_key_decode u_decode (
        .key_code  (code_reg),
        .key_class (key_class)
    );

    // Writes only happen while no line is ready and reads only while one is,
    // so the two ports never touch the same entry in overlapping cycles.
    tle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'b0, m_value_reg, m_kind_reg};
    assign m_tlast   = m_last_reg;
    assign slot_free = !m_valid_reg || m_tready;

    always_comb
    begin
        limit      = (maxb_reg > BURST) ? BURST : maxb_reg;
        diff_w     = CMP_W'(len_reg - cursor_reg);
        limit_w    = CMP_W'(limit);
        avail_w    = (diff_w < limit_w) ? diff_w : limit_w;
        avail      = avail_w[MAXB_W-1:0];
        cursor_inc = cursor_reg + LEN_W'(1);
    end

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        cursor_next     = cursor_reg;
        ready_next      = ready_reg;
        remain_next     = remain_reg;
        erase_step_next = erase_step_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_kind_next     = m_kind_reg;
        m_value_next    = m_value_reg;
        m_last_next     = m_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = len_reg[ADDR_W-1:0];
        mem_wdata       = code_reg[CHAR_W-1:0];
        mem_re          = 1'b0;
        mem_raddr       = cursor_reg[ADDR_W-1:0];
        load            = 1'b0;
        ld_kind         = KIND_NONE;
        ld_value        = '0;
        ld_last         = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (func_reg == FUNC_KEY)
                begin
                    if (raw_reg)
                    begin
                        if (slot_free)
                        begin
                            load       = 1'b1;
                            ld_kind    = KIND_RAW;
                            ld_value   = code_reg;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (ready_reg)
                    begin
                        if (slot_free)
                        begin
                            load       = 1'b1;
                            ld_kind    = KIND_REFUSED;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (key_class.is_newline)
                    begin
                        if (slot_free)
                        begin
                            load        = 1'b1;
                            ld_kind     = KIND_ECHO;
                            ld_value    = KEY_LF;
                            ready_next  = 1'b1;
                            cursor_next = '0;
                            state_next  = ST_IDLE;
                            if (len_reg < CAP_LEN)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = KEY_LF[CHAR_W-1:0];
                                len_next  = len_reg + LEN_W'(1);
                            end
                        end
                    end
                    else if (key_class.is_erase)
                    begin
                        if (len_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (slot_free)
                        begin
                            load            = 1'b1;
                            ld_kind         = KIND_ECHO;
                            ld_value        = KEY_BS;
                            ld_last         = 1'b0;
                            len_next        = len_reg - LEN_W'(1);
                            erase_step_next = 1'b0;
                            state_next      = ST_ERASE;
                        end
                    end
                    else if (key_class.is_print && (len_reg < CAP_LEN1))
                    begin
                        if (slot_free)
                        begin
                            load       = 1'b1;
                            ld_kind    = KIND_ECHO;
                            ld_value   = code_reg;
                            mem_we     = 1'b1;
                            len_next   = len_reg + LEN_W'(1);
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (raw_reg || !ready_reg)
                    begin
                        if (slot_free)
                        begin
                            load       = 1'b1;
                            ld_kind    = KIND_NONE;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (avail == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Prime the read port with the first byte of the burst.
                        mem_re      = 1'b1;
                        remain_next = avail;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_ERASE:
            begin
                if (slot_free)
                begin
                    load    = 1'b1;
                    ld_kind = KIND_ECHO;
                    if (!erase_step_reg)
                    begin
                        ld_value        = KEY_SPACE;
                        ld_last         = 1'b0;
                        erase_step_next = 1'b1;
                    end
                    else
                    begin
                        ld_value   = KEY_BS;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                // The read data register holds its byte while the output stalls.
                if (slot_free)
                begin
                    load        = 1'b1;
                    ld_kind     = KIND_DATA;
                    ld_value    = VALUE_W'(mem_rdata);
                    ld_last     = (remain_reg == MAXB_W'(1));
                    remain_next = remain_reg - MAXB_W'(1);
                    if (remain_reg == MAXB_W'(1))
                    begin
                        state_next = ST_IDLE;
                        if (cursor_inc >= len_reg)
                        begin
                            ready_next  = 1'b0;
                            len_next    = '0;
                            cursor_next = '0;
                        end
                        else
                        begin
                            cursor_next = cursor_inc;
                        end
                    end
                    else
                    begin
                        cursor_next = cursor_inc;
                        mem_re      = 1'b1;
                        mem_raddr   = cursor_inc[ADDR_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            m_valid_next = 1'b1;
            m_kind_next  = ld_kind;
            m_value_next = ld_value;
            m_last_next  = ld_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            raw_reg        <= 1'b0;
            len_reg        <= '0;
            cursor_reg     <= '0;
            ready_reg      <= 1'b0;
            remain_reg     <= '0;
            erase_step_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_kind_reg     <= '0;
            m_value_reg    <= '0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            cursor_reg     <= cursor_next;
            ready_reg      <= ready_next;
            remain_reg     <= remain_next;
            erase_step_reg <= erase_step_next;
            m_valid_reg    <= m_valid_next;
            m_kind_reg     <= m_kind_next;
            m_value_reg    <= m_value_next;
            m_last_reg     <= m_last_next;
            if (cfg_valid && cfg_ready)
            begin
                raw_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser;
            code_reg <= s_tdata[CODE_W-1:0];
            maxb_reg <= s_tdata[CODE_W+MAXB_W-1:CODE_W];
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CAP_LEN)
        else $error("line length exceeds capacity");

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (cursor_reg < len_reg))
        else $error("read cursor outside a ready line");

    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !ready_reg)
        else $error("line memory written while a line is ready");

    a_burst_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (ready_reg && (remain_reg != '0)))
        else $error("read burst without a ready line or bytes left");
`endif

endmodule

>>> rtl/tle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tle_key_decode.sv
// Classifies a key code as newline, erase or printable.
module tle_key_decode
    import tle_pkg::*;
(
    input  logic [CODE_W-1:0] key_code,
    output key_class_t        key_class
);

    always_comb
    begin
        key_class.is_newline = (key_code == KEY_LF) || (key_code == KEY_CR);
        key_class.is_erase   = (key_code == KEY_BS) || (key_code == KEY_DEL);
        key_class.is_print   = (key_code >= KEY_SPACE) && (key_code < KEY_DEL);
    end

endmodule
